FILE: hdl/fng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fng_pkg
// Shared types and constants for the face normal generator.
// ----------------------------------------------------------------------------
package fng_pkg;

    localparam int KEEP_BITS   = 30;
    localparam int NORMAL_BITS = 16;

    typedef enum logic [1:0] {
        MODE_QUADS,
        MODE_TRIANGLES,
        MODE_STRIP,
        MODE_FAN
    } prim_mode_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_FETCH1,
        SEQ_FETCH2,
        SEQ_FETCH3,
        SEQ_START,
        SEQ_WAIT,
        SEQ_OUT,
        SEQ_POST
    } seq_state_t;

    typedef enum logic [3:0] {
        NU_IDLE,
        NU_DIFF,
        NU_MUL,
        NU_ABS,
        NU_SHIFT,
        NU_SQUARE,
        NU_SQRT,
        NU_DIV,
        NU_DONE
    } nu_state_t;

    typedef struct packed {
        logic signed [NORMAL_BITS-1:0] normal_x;
        logic signed [NORMAL_BITS-1:0] normal_y;
        logic signed [NORMAL_BITS-1:0] normal_z;
        logic                          zero_length;
    } fng_result_t;

endpackage

FILE: hdl/face_normal_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_normal_generator_top
// Vertex stream in, per-corner unit face normals out (Q1.14 by default).
// ----------------------------------------------------------------------------
// One vertex word is taken at a time; s_ready is low until every normal it
// causes has been taken. Each normal goes through one shared unit: operand
// fetch and a start state, then the differences, the cross product on the
// single multiplier, the magnitudes, up to 2*COORD_BITS-29 single-bit range
// shifts (19 at defaults), the squared length, the bit-serial square root,
// the three divisions and a finish state, plus the output word, which waits
// while m_ready is low. When the cross product is zero the unit goes from
// the magnitudes straight to its finish state. After the last normal of a
// vertex the sequencer passes its post state before s_ready returns. A quad
// face costs four normals, a triangle three, each later strip or fan vertex
// one. Vertices that complete no face leave the block ready on the next
// cycle.
module face_normal_generator_top #(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_vertex_x,
    input  logic signed [COORD_BITS-1:0]  s_vertex_y,
    input  logic signed [COORD_BITS-1:0]  s_vertex_z,
    input  logic                          s_array_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_normal_x,
    output logic signed [15:0]            m_normal_y,
    output logic signed [15:0]            m_normal_z,
    output logic                          m_zero_length,
    output logic [1:0]                    m_corner,
    output logic                          m_last_of_run
);
    import fng_pkg::*;

    localparam int CW = COORD_BITS;

    seq_state_t state_reg, state_next;
    prim_mode_t mode_reg;
    logic [2:0] vcount_reg, vcount_next;
    logic       pff_reg, pff_next;
    logic [1:0] n_reg, n_next;
    logic       quad_reg, quad_next;
    logic       single_reg, single_next;
    logic       post_first_reg, post_first_next;
    logic       post_single_reg, post_single_next;
    logic       post_strip_reg, post_strip_next;

    logic [2:0][CW-1:0] store_reg [4];
    logic [2:0][CW-1:0] vtx_reg, p1_reg, p2_reg, p3_reg, rd_data, vin;

    logic       accept, emit, wr_en;
    logic [1:0] wr_addr, rd_addr, last_n, prev_n, nxt_n;
    logic       rd_vtx;
    logic [2:0] cnt0, cslot, cnext;
    logic       pff0;

    logic        nu_start, nu_done;
    fng_result_t nu_result;

    assign vin     = {s_vertex_z, s_vertex_y, s_vertex_x};
    assign accept  = s_valid && s_ready;
    assign last_n  = quad_reg ? 2'd3 : 2'd2;
    assign prev_n  = (n_reg == 2'd0) ? last_n : n_reg - 2'd1;
    assign nxt_n   = (n_reg == last_n) ? 2'd0 : n_reg + 2'd1;
    assign cnt0    = s_array_start ? 3'd0 : vcount_reg;
    assign pff0    = s_array_start ? 1'b0 : pff_reg;

    // per-vertex bookkeeping on accept
    always_comb begin
        vcount_next      = vcount_reg;
        pff_next         = pff_reg;
        quad_next        = quad_reg;
        single_next      = single_reg;
        post_first_next  = post_first_reg;
        post_single_next = post_single_reg;
        post_strip_next  = post_strip_reg;
        emit             = 1'b0;
        wr_en            = 1'b0;
        cslot            = 3'd0;
        cnext            = 3'd0;
        if (accept) begin
            pff_next         = pff0;
            post_first_next  = 1'b0;
            post_single_next = 1'b0;
            post_strip_next  = 1'b0;
            single_next      = 1'b0;
            if (mode_reg == MODE_QUADS || mode_reg == MODE_TRIANGLES) begin
                quad_next = (mode_reg == MODE_QUADS);
                if (mode_reg == MODE_QUADS) begin
                    cslot = (cnt0 >= 3'd4) ? 3'd0 : cnt0;
                    cnext = cslot + 3'd1;
                    emit  = (cnext == 3'd4);
                end else begin
                    cslot = (cnt0 >= 3'd3) ? 3'd0 : cnt0;
                    cnext = cslot + 3'd1;
                    emit  = (cnext == 3'd3);
                end
                wr_en       = 1'b1;
                vcount_next = emit ? 3'd0 : cnext;
            end else if (!pff0) begin
                quad_next   = 1'b0;
                cslot       = (cnt0 >= 3'd3) ? 3'd0 : cnt0;
                cnext       = cslot + 3'd1;
                wr_en       = 1'b1;
                vcount_next = cnext;
                emit        = (cnext == 3'd3);
                pff_next    = emit;
                post_first_next = emit;
                post_strip_next = emit && (mode_reg == MODE_STRIP);
            end else begin
                vcount_next      = cnt0;
                emit             = 1'b1;
                single_next      = 1'b1;
                post_single_next = 1'b1;
                post_strip_next  = (mode_reg == MODE_STRIP);
            end
        end
    end

    assign wr_addr = cslot[1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:   if (accept && emit) state_next = SEQ_FETCH1;
            SEQ_FETCH1: state_next = SEQ_FETCH2;
            SEQ_FETCH2: state_next = SEQ_FETCH3;
            SEQ_FETCH3: state_next = SEQ_START;
            SEQ_START:  state_next = SEQ_WAIT;
            SEQ_WAIT:   if (nu_done) state_next = SEQ_OUT;
            SEQ_OUT: begin
                if (m_ready) begin
                    state_next = m_last_of_run ? SEQ_POST : SEQ_FETCH1;
                end
            end
            SEQ_POST:   state_next = SEQ_IDLE;
            default:    state_next = SEQ_IDLE;
        endcase
    end

    // outputs and store read select
    always_comb begin
        s_ready  = (state_reg == SEQ_IDLE);
        m_valid  = (state_reg == SEQ_OUT);
        nu_start = (state_reg == SEQ_START);
        rd_vtx   = 1'b0;
        rd_addr  = n_reg;
        n_next   = n_reg;
        case (state_reg)
            SEQ_IDLE: begin
                n_next = 2'd0;
            end
            SEQ_FETCH1: begin
                rd_vtx  = single_reg;
                rd_addr = n_reg;
            end
            SEQ_FETCH2: begin
                rd_addr = single_reg ? 2'd1 : prev_n;
            end
            SEQ_FETCH3: begin
                rd_addr = single_reg ? 2'd0 : nxt_n;
            end
            SEQ_OUT: begin
                if (m_ready) n_next = n_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

    assign rd_data = rd_vtx ? vtx_reg : store_reg[rd_addr];

    assign m_normal_x    = nu_result.normal_x;
    assign m_normal_y    = nu_result.normal_y;
    assign m_normal_z    = nu_result.normal_z;
    assign m_zero_length = nu_result.zero_length;
    assign m_corner      = single_reg ? 2'd2 : n_reg;
    assign m_last_of_run = single_reg || (n_reg == last_n);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= SEQ_IDLE;
            mode_reg        <= MODE_QUADS;
            vcount_reg      <= '0;
            pff_reg         <= 1'b0;
            n_reg           <= '0;
            quad_reg        <= 1'b0;
            single_reg      <= 1'b0;
            post_first_reg  <= 1'b0;
            post_single_reg <= 1'b0;
            post_strip_reg  <= 1'b0;
        end else begin
            state_reg       <= state_next;
            if (cfg_we) mode_reg <= prim_mode_t'(cfg_wdata);
            vcount_reg      <= vcount_next;
            pff_reg         <= pff_next;
            n_reg           <= n_next;
            quad_reg        <= quad_next;
            single_reg      <= single_next;
            post_first_reg  <= post_first_next;
            post_single_reg <= post_single_next;
            post_strip_reg  <= post_strip_next;
        end
    end

    // corner store and operand registers
    always_ff @(posedge aclk) begin
        if (accept) vtx_reg <= vin;
        if (wr_en) store_reg[wr_addr] <= vin;
        if (state_reg == SEQ_POST) begin
            if (post_strip_reg) store_reg[0] <= store_reg[1];
            if (post_single_reg) begin
                store_reg[1] <= vtx_reg;
            end else if (post_first_reg) begin
                store_reg[1] <= store_reg[2];
            end
        end
        if (state_reg == SEQ_FETCH1) p1_reg <= rd_data;
        if (state_reg == SEQ_FETCH2) p2_reg <= rd_data;
        if (state_reg == SEQ_FETCH3) p3_reg <= rd_data;
    end

    fng_normal_unit #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_normal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (nu_start),
        .p1      (p1_reg),
        .p2      (p2_reg),
        .p3      (p3_reg),
        .done    (nu_done),
        .result  (nu_result)
    );

    a_zero_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_length |->
            m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0)
        else $error("zero-length normal carries nonzero components");

    a_corner_three_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_corner == 2'd3 |-> m_last_of_run && !single_reg)
        else $error("corner three is not the last normal of a quad");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_of_run |=> state_reg == SEQ_POST)
        else $error("sequencer did not close the run after its last word");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        nu_start |-> !s_ready && !m_valid)
        else $error("normal unit started while a port was open");

endmodule

FILE: hdl/fng_normal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fng_normal_unit
// Unit normal of one corner: cross product on a shared multiplier, range
// reduction by single-bit shifts, bit-serial square root and division.
// ----------------------------------------------------------------------------
module fng_normal_unit #(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [2:0][COORD_BITS-1:0]       p1,
    input  logic [2:0][COORD_BITS-1:0]       p2,
    input  logic [2:0][COORD_BITS-1:0]       p3,
    output logic                             done,
    output fng_pkg::fng_result_t             result
);
    import fng_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int MW = (DW > KEEP_BITS + 1) ? DW : KEEP_BITS + 1;
    localparam int PW = 2 * MW;
    localparam int XW = PW + 1;
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int QB = F + 1;
    localparam int NW = KEEP_BITS + F + 1;
    localparam int QX = (QB > NORMAL_BITS) ? QB : NORMAL_BITS;

    nu_state_t state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic [1:0] comp_reg, comp_next;

    logic signed [DW-1:0] a_reg [3], a_next [3];
    logic signed [DW-1:0] b_reg [3], b_next [3];
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [XW-1:0] cx_reg [3], cx_next [3];
    logic [XW-1:0] mag_reg [3], mag_next [3];
    logic [2:0] neg_reg, neg_next;
    logic [63:0] len2_reg, len2_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [NW-1:0] num_reg, num_next;
    logic [32:0] drem_reg, drem_next;
    logic [QB-1:0] q_reg, q_next;
    fng_result_t result_reg, result_next;

    logic signed [MW-1:0] mul_a, mul_b;
    logic cx_zero, over;
    logic [2:0] pidx;
    logic [33:0] rem2, trial;
    logic [32:0] dt;
    logic [QX-1:0] qx, qs;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            NU_MUL: begin
                case (step_reg[2:0])
                    3'd0: begin mul_a = MW'(a_reg[1]); mul_b = MW'(b_reg[2]); end
                    3'd1: begin mul_a = MW'(a_reg[2]); mul_b = MW'(b_reg[1]); end
                    3'd2: begin mul_a = MW'(a_reg[2]); mul_b = MW'(b_reg[0]); end
                    3'd3: begin mul_a = MW'(a_reg[0]); mul_b = MW'(b_reg[2]); end
                    3'd4: begin mul_a = MW'(a_reg[0]); mul_b = MW'(b_reg[1]); end
                    3'd5: begin mul_a = MW'(a_reg[1]); mul_b = MW'(b_reg[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            NU_SQUARE: begin
                if (step_reg < 6'd3) begin
                    mul_a = MW'({1'b0, mag_reg[step_reg[1:0]][KEEP_BITS-1:0]});
                    mul_b = mul_a;
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign cx_zero = (cx_reg[0] == '0) && (cx_reg[1] == '0) && (cx_reg[2] == '0);
    assign over    = (|mag_reg[0][XW-1:KEEP_BITS]) || (|mag_reg[1][XW-1:KEEP_BITS])
                  || (|mag_reg[2][XW-1:KEEP_BITS]);
    assign pidx    = step_reg[2:0] - 3'd1;
    assign rem2    = {rem_reg[31:0], len2_reg[63:62]};
    assign trial   = {root_reg, 2'b01};
    assign dt      = {drem_reg[31:0], num_reg[QB-1]};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            NU_IDLE:   if (start) state_next = NU_DIFF;
            NU_DIFF:   state_next = NU_MUL;
            NU_MUL:    if (step_reg == 6'd6) state_next = NU_ABS;
            NU_ABS:    state_next = cx_zero ? NU_DONE : NU_SHIFT;
            NU_SHIFT:  if (!over) state_next = NU_SQUARE;
            NU_SQUARE: if (step_reg == 6'd3) state_next = NU_SQRT;
            NU_SQRT:   if (step_reg == 6'd31) state_next = NU_DIV;
            NU_DIV:    if (step_reg == 6'(QB) && comp_reg == 2'd2) state_next = NU_DONE;
            NU_DONE:   state_next = NU_IDLE;
            default:   state_next = NU_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        done = (state_reg == NU_DONE);
    end

    assign result = result_reg;

    // datapath
    always_comb begin
        step_next   = (state_next != state_reg) ? 6'd0 : step_reg + 6'd1;
        comp_next   = comp_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        prod_next   = mul_a * mul_b;
        cx_next     = cx_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        len2_next   = len2_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        num_next    = num_reg;
        drem_next   = drem_reg;
        q_next      = q_reg;
        result_next = result_reg;
        qx          = '0;
        qs          = '0;
        case (state_reg)
            NU_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    a_next[i]  = DW'($signed(p2[i])) - DW'($signed(p1[i]));
                    b_next[i]  = DW'($signed(p3[i])) - DW'($signed(p1[i]));
                    cx_next[i] = '0;
                end
            end
            NU_MUL: begin
                if (step_reg != 6'd0) begin
                    if (pidx[0]) begin
                        cx_next[pidx[2:1]] = cx_reg[pidx[2:1]] - XW'(prod_reg);
                    end else begin
                        cx_next[pidx[2:1]] = cx_reg[pidx[2:1]] + XW'(prod_reg);
                    end
                end
            end
            NU_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    neg_next[i] = cx_reg[i][XW-1];
                    mag_next[i] = cx_reg[i][XW-1] ? XW'(-cx_reg[i]) : XW'(cx_reg[i]);
                end
                result_next = '0;
                result_next.zero_length = cx_zero;
                len2_next = '0;
            end
            NU_SHIFT: begin
                if (over) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                len2_next = '0;
            end
            NU_SQUARE: begin
                if (step_reg != 6'd0) begin
                    len2_next = len2_reg + 64'(prod_reg);
                end
                rem_next  = '0;
                root_next = '0;
            end
            NU_SQRT: begin
                len2_next = {len2_reg[61:0], 2'b00};
                if (rem2 >= trial) begin
                    rem_next  = rem2 - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end else begin
                    rem_next  = rem2;
                    root_next = {root_reg[30:0], 1'b0};
                end
                comp_next = 2'd0;
            end
            NU_DIV: begin
                if (step_reg == 6'd0) begin
                    num_next  = (NW'(mag_reg[comp_reg][KEEP_BITS-1:0]) << F)
                              + NW'(root_reg[31:1]);
                    drem_next = 33'(num_next[NW-1:QB]);
                    q_next    = '0;
                end else begin
                    num_next = num_reg << 1;
                    if (dt >= {1'b0, root_reg}) begin
                        drem_next = dt - {1'b0, root_reg};
                        q_next    = {q_reg[QB-2:0], 1'b1};
                    end else begin
                        drem_next = dt;
                        q_next    = {q_reg[QB-2:0], 1'b0};
                    end
                    if (step_reg == 6'(QB)) begin
                        qx = QX'(q_next);
                        qs = neg_reg[comp_reg] ? -qx : qx;
                        case (comp_reg)
                            2'd0:    result_next.normal_x = qs[NORMAL_BITS-1:0];
                            2'd1:    result_next.normal_y = qs[NORMAL_BITS-1:0];
                            default: result_next.normal_z = qs[NORMAL_BITS-1:0];
                        endcase
                        comp_next = comp_reg + 2'd1;
                        step_next = 6'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NU_IDLE;
            step_reg  <= '0;
            comp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            comp_reg  <= comp_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        prod_reg   <= prod_next;
        cx_reg     <= cx_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        len2_reg   <= len2_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        num_reg    <= num_next;
        drem_reg   <= drem_next;
        q_reg      <= q_next;
        result_reg <= result_next;
    end

endmodule
